// File: rtl/core/bsa_pkg.sv
package bsa_pkg;

	localparam int NUM_PROCS  = 5;
	localparam int NUM_RES    = 3;
	localparam int COUNT_BITS = 8;
	localparam int REG_BITS   = 24;
	localparam int NUM_REGS   = 6;

	localparam int PID_BITS     = 3;
	localparam int REQ_BITS     = 8;
	localparam int REG_IDX_BITS = 3;
	localparam int PIDX_BITS    = $clog2(NUM_PROCS);
	localparam int NFIN_BITS    = $clog2(NUM_PROCS + 1);
	localparam int ROW_BITS     = NUM_RES * COUNT_BITS;
	// tentative holding = held + request, need = claim - holding
	localparam int HOLD_BITS    = COUNT_BITS + 1;
	localparam int NEED_BITS    = COUNT_BITS + 2;
	// free plus every tentative holding, signed
	localparam int WORK_BITS    = HOLD_BITS + $clog2(NUM_PROCS + 1) + 1;

	localparam logic [REG_IDX_BITS-1:0] AVAIL_REG = REG_IDX_BITS'(5);

	typedef logic [1:0]            status_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [REG_BITS-1:0]   word_t;

	localparam status_t ST_GRANTED = 2'd0;
	localparam status_t ST_OVER    = 2'd1;
	localparam status_t ST_UNSAFE  = 2'd2;
	localparam status_t ST_INVALID = 2'd3;

	localparam word_t MAX_CLAIM_RST [NUM_PROCS] = '{
		24'd197895, 24'd131587, 24'd131081, 24'd131586, 24'd197380
	};
	localparam word_t AVAIL_RST = 24'd460042;

	function automatic count_t field_of(input word_t word_v, input int r);
		word_t sh;
		sh = word_v >> (r * COUNT_BITS);
		return sh[COUNT_BITS-1:0];
	endfunction

endpackage

// File: rtl/core/bankers_safety_allocator.sv
// Banker's algorithm allocator for five processes and three resource types. Each request
// on the slave stream names a process and the units it wants of each resource; one result
// per request comes out on the master stream with the grant flag, a status code and the
// free units left. A bad process number or a request above the free units is answered
// without the safety check. Otherwise the safety check walks the per-process allocation
// memory, one process per cycle (one read port, registered read data), for at most five
// sweeps of five processes, and a grant adds a write-back state. A new request is taken
// once the previous one has moved to the output register. Writing initial_available
// reloads the free pool and drops all allocations; configuration is to be written only
// while idle, and the block itself does not enforce it.
module bankers_safety_allocator (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream tdata: process_id[2:0], req_0[10:3], req_1[18:11], req_2[26:19]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	// master stream tdata: granted[0], status[2:1], avail_0[10:3], avail_1[18:11],
	// avail_2[26:19]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_CHECK  = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	localparam int NP  = bsa_pkg::NUM_PROCS;
	localparam int NR  = bsa_pkg::NUM_RES;
	localparam int CB  = bsa_pkg::COUNT_BITS;
	localparam int PB  = bsa_pkg::PIDX_BITS;
	localparam int WB  = bsa_pkg::WORK_BITS;
	localparam int HB  = bsa_pkg::HOLD_BITS;
	localparam int NB  = bsa_pkg::NEED_BITS;
	localparam int RWB = bsa_pkg::ROW_BITS;

	localparam logic [PB-1:0] LAST_IDX = PB'(NP - 1);

	logic [1:0]                    state_q;
	logic [PB-1:0]                 pid_q;
	bsa_pkg::count_t               req_q     [NR];
	bsa_pkg::count_t               free_q    [NR];
	bsa_pkg::word_t                maxc_q    [NP];
	logic signed [WB-1:0]          work_q    [NR];
	logic [NP-1:0]                 done_q;
	logic [NP-1:0]                 valid_q;
	logic [bsa_pkg::NFIN_BITS-1:0] nfin_q;
	logic [PB-1:0]                 pass_q;
	logic                          prog_q;
	logic [PB-1:0]                 ptr_q;
	logic [RWB-1:0]                hold_p_q;
	bsa_pkg::status_t              status_q;
	logic                          m_tvalid_q;
	logic [31:0]                   m_tdata_q;

	// allocation memory, one row of NR counts per process
	logic [RWB-1:0] held_mem [NP];
	logic [RWB-1:0] rd_row_s1;
	logic           rd_rowvld_s1;
	logic           rd_vld_s1;
	logic [PB-1:0]  eval_idx_s1;

	// incoming request
	logic [bsa_pkg::PID_BITS-1:0] in_pid;
	bsa_pkg::count_t              in_req [NR];
	logic                         accept;
	logic                         in_over;
	logic                         in_invalid;

	// evaluation of one process against work
	logic [RWB-1:0]       row_v;
	logic [HB-1:0]        hold_v [NR];
	logic signed [NB-1:0] need_v [NR];
	logic                 fits;
	logic                 do_eval;
	logic                 take;
	logic [bsa_pkg::NFIN_BITS-1:0] nfin_nx;
	logic                 last_idx;

	// commit
	logic [RWB-1:0] commit_row;
	logic           commit_we;
	logic           out_load;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	assign in_pid = s_axis_tdata[bsa_pkg::PID_BITS-1:0];

	always_comb begin
		in_over = 1'b0;
		for (int r = 0; r < NR; r++) begin
			in_req[r] = s_axis_tdata[bsa_pkg::PID_BITS + r*bsa_pkg::REQ_BITS +: CB];
			if (in_req[r] > free_q[r])
				in_over = 1'b1;
		end
	end

	assign in_invalid = ({1'b0, in_pid} >= (bsa_pkg::PID_BITS + 1)'(NP));

	always_comb begin
		row_v = rd_rowvld_s1 ? rd_row_s1 : '0;
		fits  = 1'b1;
		for (int r = 0; r < NR; r++) begin
			hold_v[r] = {1'b0, row_v[r*CB +: CB]}
				+ ((eval_idx_s1 == pid_q) ? {1'b0, req_q[r]} : HB'(0));
			need_v[r] = $signed({2'b00, bsa_pkg::field_of(maxc_q[eval_idx_s1], r)})
				- $signed({1'b0, hold_v[r]});
			if (WB'(need_v[r]) > work_q[r])
				fits = 1'b0;
		end
	end

	assign do_eval  = (state_q == S_CHECK) && rd_vld_s1;
	assign take     = do_eval && !done_q[eval_idx_s1] && fits;
	assign nfin_nx  = nfin_q + bsa_pkg::NFIN_BITS'(take);
	assign last_idx = (eval_idx_s1 == LAST_IDX);

	// saturating write-back of the granted row
	always_comb begin
		logic [CB:0] sum;
		sum = '0;
		for (int r = 0; r < NR; r++) begin
			sum = {1'b0, hold_p_q[r*CB +: CB]} + {1'b0, req_q[r]};
			commit_row[r*CB +: CB] = sum[CB] ? {CB{1'b1}} : sum[CB-1:0];
		end
	end

	assign commit_we = (state_q == S_COMMIT);
	assign out_load  = (state_q == S_FINISH) && (!m_tvalid_q || m_axis_tready);

	always_ff @(posedge clk) begin
		if (commit_we)
			held_mem[pid_q] <= commit_row;
		rd_row_s1 <= held_mem[ptr_q];
		if (do_eval && (eval_idx_s1 == pid_q))
			hold_p_q <= row_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pid_q        <= '0;
			done_q       <= '0;
			valid_q      <= '0;
			nfin_q       <= '0;
			pass_q       <= '0;
			prog_q       <= 1'b0;
			ptr_q        <= '0;
			status_q     <= bsa_pkg::ST_GRANTED;
			rd_vld_s1    <= 1'b0;
			rd_rowvld_s1 <= 1'b0;
			eval_idx_s1  <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			for (int i = 0; i < NP; i++)
				maxc_q[i] <= bsa_pkg::MAX_CLAIM_RST[i];
			for (int r = 0; r < NR; r++) begin
				free_q[r] <= bsa_pkg::field_of(bsa_pkg::AVAIL_RST, r);
				req_q[r]  <= '0;
				work_q[r] <= '0;
			end
		end else begin
			rd_vld_s1    <= (state_q == S_CHECK);
			rd_rowvld_s1 <= valid_q[ptr_q];
			eval_idx_s1  <= ptr_q;

			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_axis_tready)
				m_tvalid_q <= 1'b0;

			if (cfg_valid) begin
				if (cfg_index == bsa_pkg::AVAIL_REG) begin
					valid_q <= '0;
					for (int r = 0; r < NR; r++)
						free_q[r] <= bsa_pkg::field_of(cfg_data, r);
				end else if ({1'b0, cfg_index} < (bsa_pkg::REG_IDX_BITS + 1)'(NP)) begin
					maxc_q[cfg_index[PB-1:0]] <= cfg_data;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pid_q <= in_pid[PB-1:0];
						for (int r = 0; r < NR; r++)
							req_q[r] <= in_req[r];
						if (in_invalid) begin
							status_q <= bsa_pkg::ST_INVALID;
							state_q  <= S_FINISH;
						end else if (in_over) begin
							status_q <= bsa_pkg::ST_OVER;
							state_q  <= S_FINISH;
						end else begin
							for (int r = 0; r < NR; r++)
								work_q[r] <= $signed({{(WB-CB){1'b0}}, free_q[r]})
									- $signed({{(WB-CB){1'b0}}, in_req[r]});
							done_q  <= '0;
							nfin_q  <= '0;
							pass_q  <= '0;
							prog_q  <= 1'b0;
							ptr_q   <= '0;
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
					if (do_eval) begin
						if (take) begin
							for (int r = 0; r < NR; r++)
								work_q[r] <= work_q[r] + $signed({{(WB-HB){1'b0}}, hold_v[r]});
							done_q[eval_idx_s1] <= 1'b1;
							nfin_q <= nfin_nx;
						end
						if (nfin_nx == bsa_pkg::NFIN_BITS'(NP)) begin
							state_q <= S_COMMIT;
						end else if (last_idx) begin
							// end of a sweep: stop when nobody finished or sweeps ran out
							if (!(prog_q || take) || pass_q == LAST_IDX) begin
								status_q <= bsa_pkg::ST_UNSAFE;
								state_q  <= S_FINISH;
							end else begin
								pass_q <= pass_q + 1'b1;
								prog_q <= 1'b0;
							end
						end else begin
							prog_q <= prog_q || take;
						end
					end
				end
				S_COMMIT: begin
					valid_q[pid_q] <= 1'b1;
					for (int r = 0; r < NR; r++)
						free_q[r] <= free_q[r] - req_q[r];
					status_q <= bsa_pkg::ST_GRANTED;
					state_q  <= S_FINISH;
				end
				S_FINISH: begin
					if (out_load) begin
						m_tdata_q  <= {5'd0, free_q[2], free_q[1], free_q[0], status_q,
							status_q == bsa_pkg::ST_GRANTED};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
